@@ hw/rtl/crc8_pulse_distance_packet_transmitter_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef CRC8_PULSE_DISTANCE_PACKET_TRANSMITTER_MACROS_SVH
`define CRC8_PULSE_DISTANCE_PACKET_TRANSMITTER_MACROS_SVH

// expr holds at every clock edge out of reset
`define CPDT_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("assertion failed");

// same-cycle implication
`define CPDT_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CPDT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/cpdt_pkg.sv @@
package cpdt_pkg;

    localparam int TimerBits = 12;
    localparam logic [31:0] TimerMax = (32'd1 << TimerBits) - 32'd1;
    localparam int DurW = 12;
    localparam int FrameBits = 48;
    localparam int PosW = 6;
    localparam logic [PosW-1:0] PosLast = PosW'(FrameBits - 1);

    localparam logic [7:0] CrcPoly = 8'h07;
    localparam logic [7:0] CrcInit = 8'h84;

    localparam logic [DurW-1:0] SyncHalfRst = 12'd550;
    localparam logic [DurW-1:0] BitLowRst = 12'd220;
    localparam logic [DurW-1:0] ZeroHighRst = 12'd220;
    localparam logic [DurW-1:0] OneHighRst = 12'd380;
    localparam logic [2:0] RepeatRst = 3'd2;
    localparam logic [7:0] LeadRst = 8'h5F;
    localparam logic [7:0] FixedRst = 8'hFF;
    localparam logic [7:0] GroupRst = 8'h13;

    localparam int AddrW = 5;

    typedef enum logic [2:0] {
        REG_SYNC_HALF = 3'd0,
        REG_BIT_LOW = 3'd1,
        REG_ZERO_HIGH = 3'd2,
        REG_ONE_HIGH = 3'd3,
        REG_REPEAT = 3'd4,
        REG_LEAD = 3'd5,
        REG_FIXED = 3'd6,
        REG_GROUP = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SYNC_LOW = 3'd1,
        PH_SYNC_HIGH = 3'd2,
        PH_BIT_LOW = 3'd3,
        PH_BIT_HIGH = 3'd4
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] payload_first;
        logic [7:0] payload_second;
    } in_t;

    typedef struct packed {
        logic       line_level;
        logic       busy_res;
        logic [7:0] frame_crc;
        logic       frame_done;
    } out_t;

    typedef struct packed {
        logic [DurW-1:0] sync_half_us;
        logic [DurW-1:0] bit_low_us;
        logic [DurW-1:0] zero_high_us;
        logic [DurW-1:0] one_high_us;
        logic [2:0]      repeat_count;
        logic [7:0]      lead_byte;
        logic [7:0]      fixed_byte;
        logic [7:0]      group_byte;
    } cfg_t;

    function automatic logic [7:0] rev8(logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ rev8(data);
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [TimerBits-1:0] load_len(logic [DurW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            w = 32'd1;
        end
        if (w > TimerMax) begin
            w = TimerMax;
        end
        return w[TimerBits-1:0];
    endfunction

endpackage

@@ hw/rtl/crc8_pulse_distance_packet_transmitter.sv @@
// an accepted request's result is registered and appears in the output register in the next cycle
// throughput: one request per cycle; a new request is taken while the result is taken
// the output register frees itself on the same edge, so only a stalled m_ready holds input
// reset (aresetn low, synchronous): line idles high, phase idle, crc 0, config to defaults
// a start request while a frame is in progress is ignored and produces an unchanged result
module crc8_pulse_distance_packet_transmitter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  cpdt_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output cpdt_pkg::out_t             m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpdt_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    `include "crc8_pulse_distance_packet_transmitter_macros.svh"

    cpdt_pkg::cfg_t cfg;
    logic [7:0]     crc_new;

    cpdt_pkg::phase_t                   phase_reg, phase_next;
    logic [cpdt_pkg::FrameBits-1:0]     frame_reg, frame_next;
    logic [cpdt_pkg::PosW-1:0]          pos_reg, pos_next;
    logic [2:0]                         rep_reg, rep_next;
    logic [cpdt_pkg::TimerBits-1:0]     ticks_reg, ticks_next;
    logic                               line_reg, line_next;
    logic [7:0]                         crc_reg, crc_next;
    logic                               done_next;
    logic                               m_valid_reg;
    cpdt_pkg::out_t                     m_data_reg;

    logic                               accept;
    logic                               is_idle;
    logic                               start;
    logic                               tick;
    logic [cpdt_pkg::TimerBits-1:0]     ticks_dec;
    logic                               expire;
    logic                               cur_bit;
    logic [cpdt_pkg::PosW-1:0]          bit_idx;

    cpdt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpdt_crc u_crc (
        .cfg            (cfg),
        .payload_first  (s_data.payload_first),
        .payload_second (s_data.payload_second),
        .crc            (crc_new)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    assign is_idle = (phase_reg == cpdt_pkg::PH_IDLE);
    assign start = accept && s_data.action && is_idle;
    assign tick = accept && !s_data.action && !is_idle;
    assign ticks_dec = (ticks_reg == '0) ? '0 : ticks_reg - 1'b1;
    assign expire = tick && (ticks_dec == '0);
    assign bit_idx = cpdt_pkg::PosLast - pos_reg;
    assign cur_bit = frame_reg[bit_idx];

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (start) begin
            phase_next = cpdt_pkg::PH_SYNC_LOW;
        end else if (expire) begin
            case (phase_reg)
                cpdt_pkg::PH_SYNC_LOW:  phase_next = cpdt_pkg::PH_SYNC_HIGH;
                cpdt_pkg::PH_SYNC_HIGH: phase_next = cpdt_pkg::PH_BIT_LOW;
                cpdt_pkg::PH_BIT_LOW:   phase_next = cpdt_pkg::PH_BIT_HIGH;
                cpdt_pkg::PH_BIT_HIGH: begin
                    if (pos_reg < cpdt_pkg::PosLast) begin
                        phase_next = cpdt_pkg::PH_BIT_LOW;
                    end else if (rep_reg > 3'd1) begin
                        phase_next = cpdt_pkg::PH_SYNC_LOW;
                    end else begin
                        phase_next = cpdt_pkg::PH_IDLE;
                    end
                end
                default: phase_next = cpdt_pkg::PH_IDLE;
            endcase
        end
    end

    // datapath and result fields
    always_comb begin
        frame_next = frame_reg;
        pos_next = pos_reg;
        rep_next = rep_reg;
        ticks_next = ticks_reg;
        line_next = line_reg;
        crc_next = crc_reg;
        done_next = 1'b0;
        if (start) begin
            frame_next = {cfg.lead_byte, s_data.payload_first, s_data.payload_second,
                          cfg.fixed_byte, cfg.group_byte, crc_new};
            crc_next = crc_new;
            rep_next = (cfg.repeat_count == 3'd0) ? 3'd1 : cfg.repeat_count;
            pos_next = '0;
            line_next = 1'b0;
            ticks_next = cpdt_pkg::load_len(cfg.sync_half_us);
        end else if (tick) begin
            ticks_next = ticks_dec;
            if (expire) begin
                case (phase_reg)
                    cpdt_pkg::PH_SYNC_LOW: begin
                        line_next = 1'b1;
                        ticks_next = cpdt_pkg::load_len(cfg.sync_half_us);
                    end
                    cpdt_pkg::PH_SYNC_HIGH: begin
                        pos_next = '0;
                        line_next = 1'b0;
                        ticks_next = cpdt_pkg::load_len(cfg.bit_low_us);
                    end
                    cpdt_pkg::PH_BIT_LOW: begin
                        line_next = 1'b1;
                        ticks_next = cpdt_pkg::load_len(cur_bit ? cfg.one_high_us
                                                                : cfg.zero_high_us);
                    end
                    default: begin
                        if (pos_reg < cpdt_pkg::PosLast) begin
                            pos_next = pos_reg + 1'b1;
                            line_next = 1'b0;
                            ticks_next = cpdt_pkg::load_len(cfg.bit_low_us);
                        end else if (rep_reg > 3'd1) begin
                            rep_next = rep_reg - 3'd1;
                            pos_next = '0;
                            line_next = 1'b0;
                            ticks_next = cpdt_pkg::load_len(cfg.sync_half_us);
                        end else begin
                            rep_next = 3'd0;
                            pos_next = '0;
                            line_next = 1'b1;
                            ticks_next = '0;
                            done_next = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cpdt_pkg::PH_IDLE;
            pos_reg <= '0;
            rep_reg <= 3'd0;
            ticks_reg <= '0;
            line_reg <= 1'b1;
            crc_reg <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                pos_reg <= pos_next;
                rep_reg <= rep_next;
                ticks_reg <= ticks_next;
                line_reg <= line_next;
                crc_reg <= crc_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            frame_reg <= frame_next;
            m_data_reg.line_level <= line_next;
            m_data_reg.busy_res <= (phase_next != cpdt_pkg::PH_IDLE);
            m_data_reg.frame_crc <= crc_next;
            m_data_reg.frame_done <= done_next;
        end
    end

    `CPDT_ASSERT_IMPLIES(a_idle_high, phase_reg == cpdt_pkg::PH_IDLE, line_reg)
    `CPDT_ASSERT_IMPLIES(a_timer_live, phase_reg != cpdt_pkg::PH_IDLE, ticks_reg != '0)
    `CPDT_ASSERT_IMPLIES(a_done_not_busy, m_valid && m_data.frame_done, !m_data.busy_res)
    `CPDT_ASSERT_NEXT(a_start_sync, start,
        phase_reg == cpdt_pkg::PH_SYNC_LOW && !line_reg && m_valid)

endmodule

@@ hw/rtl/cpdt_regs.sv @@
module cpdt_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpdt_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output cpdt_pkg::cfg_t             cfg
);

    cpdt_pkg::cfg_t     cfg_reg;
    cpdt_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx = cpdt_pkg::reg_idx_t'(paddr[cpdt_pkg::AddrW-1:2]);
    assign wr_en = psel && penable && pwrite && pready;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_half_us <= cpdt_pkg::SyncHalfRst;
            cfg_reg.bit_low_us <= cpdt_pkg::BitLowRst;
            cfg_reg.zero_high_us <= cpdt_pkg::ZeroHighRst;
            cfg_reg.one_high_us <= cpdt_pkg::OneHighRst;
            cfg_reg.repeat_count <= cpdt_pkg::RepeatRst;
            cfg_reg.lead_byte <= cpdt_pkg::LeadRst;
            cfg_reg.fixed_byte <= cpdt_pkg::FixedRst;
            cfg_reg.group_byte <= cpdt_pkg::GroupRst;
        end else if (wr_en) begin
            case (idx)
                cpdt_pkg::REG_SYNC_HALF: cfg_reg.sync_half_us <= pwdata[cpdt_pkg::DurW-1:0];
                cpdt_pkg::REG_BIT_LOW:   cfg_reg.bit_low_us <= pwdata[cpdt_pkg::DurW-1:0];
                cpdt_pkg::REG_ZERO_HIGH: cfg_reg.zero_high_us <= pwdata[cpdt_pkg::DurW-1:0];
                cpdt_pkg::REG_ONE_HIGH:  cfg_reg.one_high_us <= pwdata[cpdt_pkg::DurW-1:0];
                cpdt_pkg::REG_REPEAT:    cfg_reg.repeat_count <= pwdata[2:0];
                cpdt_pkg::REG_LEAD:      cfg_reg.lead_byte <= pwdata[7:0];
                cpdt_pkg::REG_FIXED:     cfg_reg.fixed_byte <= pwdata[7:0];
                cpdt_pkg::REG_GROUP:     cfg_reg.group_byte <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            cpdt_pkg::REG_SYNC_HALF: prdata = 32'(cfg_reg.sync_half_us);
            cpdt_pkg::REG_BIT_LOW:   prdata = 32'(cfg_reg.bit_low_us);
            cpdt_pkg::REG_ZERO_HIGH: prdata = 32'(cfg_reg.zero_high_us);
            cpdt_pkg::REG_ONE_HIGH:  prdata = 32'(cfg_reg.one_high_us);
            cpdt_pkg::REG_REPEAT:    prdata = 32'(cfg_reg.repeat_count);
            cpdt_pkg::REG_LEAD:      prdata = 32'(cfg_reg.lead_byte);
            cpdt_pkg::REG_FIXED:     prdata = 32'(cfg_reg.fixed_byte);
            cpdt_pkg::REG_GROUP:     prdata = 32'(cfg_reg.group_byte);
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

@@ hw/rtl/cpdt_crc.sv @@
module cpdt_crc (
    input  cpdt_pkg::cfg_t cfg,
    input  logic [7:0]     payload_first,
    input  logic [7:0]     payload_second,
    output logic [7:0]     crc
);

    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    logic [7:0] c4;

    // reflected crc-8 over the five header bytes
    assign c0 = cpdt_pkg::crc_byte(cpdt_pkg::CrcInit, cfg.lead_byte);
    assign c1 = cpdt_pkg::crc_byte(c0, payload_first);
    assign c2 = cpdt_pkg::crc_byte(c1, payload_second);
    assign c3 = cpdt_pkg::crc_byte(c2, cfg.fixed_byte);
    assign c4 = cpdt_pkg::crc_byte(c3, cfg.group_byte);
    assign crc = cpdt_pkg::rev8(c4);

endmodule

@@ tb/sv/frame_line_checker.sv @@
`timescale 1ns / 1ps

module frame_line_checker
    import cpdt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_t              s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_t             m_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic             pready,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output int               bad_results,
    output int               pending
);

    // reflected form of poly 0x07 and seed 0x84
    localparam logic [7:0] ReflPoly = 8'hE0;
    localparam logic [7:0] ReflSeed = 8'h21;

    cfg_t                cfg;
    logic [FrameBits-1:0] frame_word;
    phase_t              ph;
    logic [PosW-1:0]     bit_idx;
    logic [2:0]          copies_left;
    logic [DurW-1:0]     ticks_to_go;
    logic                level;
    logic [7:0]          crc_last;
    out_t                expected_line [$];

    function automatic logic [DurW-1:0] span(logic [DurW-1:0] v);
        return (v == '0) ? DurW'(1) : v;
    endfunction

    function automatic logic [7:0] frame_check_byte(logic [39:0] head);
        logic [7:0] c;
        c = ReflSeed;
        for (int i = 4; i >= 0; i--) begin
            c = c ^ head[8*i +: 8];
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ ReflPoly) : (c >> 1);
            end
        end
        return c;
    endfunction

    function automatic out_t advance(in_t req);
        logic [39:0] head;
        out_t        r;
        r.frame_done = 1'b0;
        if (req.action) begin
            if (ph == PH_IDLE) begin
                head = {cfg.lead_byte, req.payload_first, req.payload_second,
                        cfg.fixed_byte, cfg.group_byte};
                crc_last = frame_check_byte(head);
                frame_word = {head, crc_last};
                copies_left = (cfg.repeat_count == '0) ? 3'd1 : cfg.repeat_count;
                bit_idx = '0;
                ph = PH_SYNC_LOW;
                level = 1'b0;
                ticks_to_go = span(cfg.sync_half_us);
            end
        end else if (ph != PH_IDLE) begin
            if (ticks_to_go != '0) ticks_to_go--;
            if (ticks_to_go == '0) begin
                case (ph)
                    PH_SYNC_LOW: begin
                        ph = PH_SYNC_HIGH;
                        level = 1'b1;
                        ticks_to_go = span(cfg.sync_half_us);
                    end
                    PH_SYNC_HIGH: begin
                        ph = PH_BIT_LOW;
                        bit_idx = '0;
                        level = 1'b0;
                        ticks_to_go = span(cfg.bit_low_us);
                    end
                    PH_BIT_LOW: begin
                        ph = PH_BIT_HIGH;
                        level = 1'b1;
                        ticks_to_go = span(frame_word[FrameBits - 1 - bit_idx] ?
                                           cfg.one_high_us : cfg.zero_high_us);
                    end
                    default: begin
                        if (bit_idx < PosLast) begin
                            bit_idx++;
                            ph = PH_BIT_LOW;
                            level = 1'b0;
                            ticks_to_go = span(cfg.bit_low_us);
                        end else if (copies_left > 3'd1) begin
                            copies_left--;
                            bit_idx = '0;
                            ph = PH_SYNC_LOW;
                            level = 1'b0;
                            ticks_to_go = span(cfg.sync_half_us);
                        end else begin
                            copies_left = '0;
                            bit_idx = '0;
                            ph = PH_IDLE;
                            level = 1'b1;
                            ticks_to_go = '0;
                            r.frame_done = 1'b1;
                        end
                    end
                endcase
            end
        end
        r.line_level = level;
        r.busy_res = (ph != PH_IDLE);
        r.frame_crc = crc_last;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        out_t want;
        if (!aresetn) begin
            cfg = '{SyncHalfRst, BitLowRst, ZeroHighRst, OneHighRst,
                    RepeatRst, LeadRst, FixedRst, GroupRst};
            frame_word = '0;
            ph = PH_IDLE;
            bit_idx = '0;
            copies_left = '0;
            ticks_to_go = '0;
            level = 1'b1;
            crc_last = '0;
            expected_line.delete();
            bad_results = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[AddrW-1:2]))
                    REG_SYNC_HALF: cfg.sync_half_us = pwdata[DurW-1:0];
                    REG_BIT_LOW:   cfg.bit_low_us = pwdata[DurW-1:0];
                    REG_ZERO_HIGH: cfg.zero_high_us = pwdata[DurW-1:0];
                    REG_ONE_HIGH:  cfg.one_high_us = pwdata[DurW-1:0];
                    REG_REPEAT:    cfg.repeat_count = pwdata[2:0];
                    REG_LEAD:      cfg.lead_byte = pwdata[7:0];
                    REG_FIXED:     cfg.fixed_byte = pwdata[7:0];
                    REG_GROUP:     cfg.group_byte = pwdata[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_line.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("unexpected result: line %0b busy %0b crc %02h done %0b",
                                 m_data.line_level, m_data.busy_res,
                                 m_data.frame_crc, m_data.frame_done);
                    end
                end else begin
                    want = expected_line.pop_front();
                    if (m_data.line_level !== want.line_level ||
                        m_data.busy_res !== want.busy_res ||
                        m_data.frame_crc !== want.frame_crc ||
                        m_data.frame_done !== want.frame_done) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("wrong result: expected line %0b busy %0b crc %02h done %0b",
                                     want.line_level, want.busy_res,
                                     want.frame_crc, want.frame_done);
                            $display("              actual   line %0b busy %0b crc %02h done %0b",
                                     m_data.line_level, m_data.busy_res,
                                     m_data.frame_crc, m_data.frame_done);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_line.push_back(advance(s_data));
            end
        end
        pending = expected_line.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import cpdt_pkg::*;

    localparam int TargetRequests = 1850;
    localparam int QuietLimit = 4000;
    localparam logic ActTick = 1'b0;
    localparam logic ActStart = 1'b1;

    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKED} rx_mode_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_t              s_data;
    logic             m_valid;
    logic             m_ready;
    out_t             m_data;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    int          bad_results;
    int          pending;
    int          quiet_cycles;
    int          burst_left;
    int          requests_sent;
    rx_mode_t    rx_mode;
    int          rx_left;
    int          rx_count;
    logic [31:0] shadow [8];

    crc8_pulse_distance_packet_transmitter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frame_line_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .bad_results (bad_results),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        rx_count++;
        case (rx_mode)
            RX_OPEN:     m_ready = 1'b1;
            RX_COIN:     m_ready = 1'($urandom_range(0, 1));
            RX_PERIODIC: m_ready = (rx_count % 5) < 3;
            default:     m_ready = ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QuietLimit) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    task automatic send(logic act, logic [7:0] a, logic [7:0] b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            if ($urandom_range(0, 2) != 0) begin
                s_valid = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid = 1'b1;
        s_data.action = act;
        s_data.payload_first = a;
        s_data.payload_second = b;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic ticks(int n);
        for (int i = 0; i < n; i++) begin
            send(ActTick, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(reg_idx_t r, logic [31:0] v);
        logic [31:0] keep;
        keep = (r == REG_REPEAT) ? 32'h7 : (r >= REG_LEAD) ? 32'hFF : 32'hFFF;
        shadow[r] = v & keep;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {r, 2'b00};
        pwdata = (v & keep) | ($urandom & ~keep);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic int at_least_one(logic [31:0] v);
        return (v == 0) ? 1 : int'(v);
    endfunction

    // upper bound on the ticks that one whole frame needs
    function automatic int frame_ticks();
        int reps;
        int high;
        reps = at_least_one(shadow[REG_REPEAT]);
        high = at_least_one(shadow[REG_ZERO_HIGH]);
        if (at_least_one(shadow[REG_ONE_HIGH]) > high) high = at_least_one(shadow[REG_ONE_HIGH]);
        return reps * (2 * at_least_one(shadow[REG_SYNC_HALF]) +
                       48 * (at_least_one(shadow[REG_BIT_LOW]) + high));
    endfunction

    function automatic logic [31:0] pick_value(reg_idx_t r);
        int roll;
        roll = $urandom_range(0, 9);
        case (r)
            REG_REPEAT: begin
                if (roll < 6) return $urandom_range(0, 2);
                if (roll < 9) return 3;
                return 7;
            end
            REG_LEAD, REG_FIXED, REG_GROUP: begin
                if (roll == 0) return 32'h00;
                if (roll == 1) return 32'hFF;
                return $urandom_range(0, 255);
            end
            default: begin
                if (roll == 0) return 0;
                if (roll < 7) return 1;
                if (roll < 9) return 2;
                return $urandom_range(3, 5);
            end
        endcase
    endfunction

    task automatic reconfigure();
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 1) == 1) write_reg(reg_idx_t'(i), pick_value(reg_idx_t'(i)));
        end
    endtask

    task automatic frame_request();
        int n;
        send(ActStart, 8'($urandom), 8'($urandom));
        n = frame_ticks() + $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) send(ActStart, 8'($urandom), 8'($urandom));
            else send(ActTick, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 24)) begin
            send(1'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        requests_sent = 0;
        quiet_cycles = 0;
        rx_left = 0;
        rx_count = 0;
        shadow[REG_SYNC_HALF] = 32'(SyncHalfRst);
        shadow[REG_BIT_LOW] = 32'(BitLowRst);
        shadow[REG_ZERO_HIGH] = 32'(ZeroHighRst);
        shadow[REG_ONE_HIGH] = 32'(OneHighRst);
        shadow[REG_REPEAT] = 32'(RepeatRst);
        shadow[REG_LEAD] = 32'(LeadRst);
        shadow[REG_FIXED] = 32'(FixedRst);
        shadow[REG_GROUP] = 32'(GroupRst);
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ticks while idle, then a frame at reset settings and a start while busy
        send(ActTick, 8'hFF, 8'h00);
        send(ActTick, 8'h00, 8'hFF);
        send(ActStart, 8'h00, 8'h00);
        send(ActStart, 8'hFF, 8'hFF);
        ticks(2);
        drain();

        // zero low time, single copy, long one-bit high time
        write_reg(REG_SYNC_HALF, 1);
        write_reg(REG_BIT_LOW, 0);
        write_reg(REG_ZERO_HIGH, 1);
        write_reg(REG_ONE_HIGH, 64);
        write_reg(REG_REPEAT, 0);
        ticks(600);
        drain();
        write_reg(REG_ONE_HIGH, 1);
        ticks(220);
        drain();

        write_reg(REG_LEAD, 8'h00);
        write_reg(REG_FIXED, 8'h00);
        write_reg(REG_GROUP, 8'h00);
        write_reg(REG_REPEAT, 7);
        send(ActStart, 8'h00, 8'h00);
        ticks(frame_ticks() + 2);
        drain();

        write_reg(REG_LEAD, 8'hFF);
        write_reg(REG_FIXED, 8'hFF);
        write_reg(REG_GROUP, 8'hFF);
        write_reg(REG_REPEAT, 1);
        send(ActStart, 8'hFF, 8'hFF);
        ticks(frame_ticks() + 2);

        while (requests_sent < TargetRequests) begin
            if ($urandom_range(0, 3) == 0) begin
                drain();
                reconfigure();
            end
            if ($urandom_range(0, 4) == 0) noise_burst();
            else frame_request();
        end
        drain();

        if (bad_results == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/cpdt_pkg.sv
hw/rtl/cpdt_regs.sv
hw/rtl/cpdt_crc.sv
hw/rtl/crc8_pulse_distance_packet_transmitter.sv
tb/sv/frame_line_checker.sv
tb/sv/testbench.sv
